// ===== hw/rtl/swm_pkg.sv =====
// shared types, constants and helper functions for the sliding window maximum block
package swm_pkg;

    localparam int WINDOW_MAX   = 64;
    localparam int SAMPLE_WIDTH = 16;
    localparam int CFG_W        = 7;
    localparam int ADDR_W       = $clog2(WINDOW_MAX);
    localparam int CNT_W        = $clog2(WINDOW_MAX + 1);
    localparam int POS_MOD      = 2 * WINDOW_MAX;
    localparam int POS_W        = $clog2(POS_MOD);

    typedef logic [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic [ADDR_W-1:0]       t_slot;
    typedef logic [CNT_W-1:0]        t_cnt;
    typedef logic [POS_W-1:0]        t_pos;
    typedef logic [CFG_W-1:0]        t_cfg;

    // one deque cell
    typedef struct packed {
        t_sample value;
        t_pos    pos;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FRONT_RD,
        ST_FRONT_CHK,
        ST_BACK_RD,
        ST_BACK_CHK,
        ST_PUSH,
        ST_HEAD_RD,
        ST_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rd_en;
        logic rd_back;
        logic drop_head;
        logic drop_tail;
        logic push;
        logic load_out;
        logic clear;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic occ_zero;
        logic front_stale;
        logic back_drop;
        logic emit_req;
        logic is_last;
        logic out_free;
    } t_sts;

    function automatic t_slot slot_next(input t_slot s);
        t_slot r;
        r = (int'(s) == WINDOW_MAX - 1) ? t_slot'(0) : t_slot'(s + t_slot'(1));
        return r;
    endfunction

    function automatic t_slot slot_prev(input t_slot s);
        t_slot r;
        r = (s == t_slot'(0)) ? t_slot'(WINDOW_MAX - 1) : t_slot'(s - t_slot'(1));
        return r;
    endfunction

endpackage

// ===== hw/rtl/swm_if.sv =====
// stream and configuration channel interfaces of the sliding window maximum block

interface swm_smp_if;
    logic                 valid;
    logic                 ready;
    swm_pkg::t_sample     sample_value;
    logic                 array_end;

    modport source (output valid, output sample_value, output array_end, input ready);
    modport sink   (input valid, input sample_value, input array_end, output ready);
endinterface

interface swm_res_if;
    logic                 valid;
    logic                 ready;
    swm_pkg::t_sample     window_max;
    logic                 last_of_array;

    modport source (output valid, output window_max, output last_of_array, input ready);
    modport sink   (input valid, input window_max, input last_of_array, output ready);
endinterface

interface swm_cfg_if;
    logic                 valid;
    logic                 ready;
    swm_pkg::t_cfg        window_size;

    modport source (output valid, output window_size, input ready);
    modport sink   (input valid, input window_size, output ready);
endinterface

// ===== hw/rtl/sliding_window_maximum.sv =====
// sliding window maximum top level: config register, controller and datapath
//
// i_smp carries one sample beat (sample_value, array_end) per valid/ready handshake.
// o_res carries one result beat (window_max, last_of_array) per handshake.
// i_cfg writes window_size; it is always ready and is meant to be written while idle.
// window_size 0 acts as 1 and values above 64 act as 64; reset value is 1.
// once window_size samples of an array have arrived each sample gives one result;
// the sample flagged array_end always gives a result flagged last_of_array and then
// the deque, position and fill count are cleared for the next array.
// each sample is worked in order: front read and check (again for each stale head
// candidate dropped), back read and check (again for each tail candidate not above
// the sample dropped), push, head read, emit. the deque memory has a registered
// read, so each candidate is read and then checked. a new sample is accepted only
// after the emit step of the one before.
// the output register holds one result; if the receiver stalls, the next sample is
// still taken and worked, and the block waits before its emit step until the
// register frees up. synchronous active low reset clears all control state; the
// deque memory needs no clearing since data read from unoccupied cells is never used.
module sliding_window_maximum (
    input  logic      i_clk,
    input  logic      i_rst_n,
    swm_cfg_if.sink   i_cfg,
    swm_smp_if.sink   i_smp,
    swm_res_if.source o_res
);

    swm_pkg::t_cfg r_window_size;
    swm_pkg::t_cnt w_k;
    swm_pkg::t_cmd w_cmd;
    swm_pkg::t_sts w_sts;
    logic          w_in_ready;

    // configuration register, always ready
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= swm_pkg::t_cfg'(1);
        end else if (i_cfg.valid) begin
            r_window_size <= i_cfg.window_size;
        end
    end

    // effective window: zero acts as one, saturate at the deque depth
    always_comb begin
        if (r_window_size == '0) begin
            w_k = swm_pkg::t_cnt'(1);
        end else if (int'(r_window_size) > swm_pkg::WINDOW_MAX) begin
            w_k = swm_pkg::t_cnt'(swm_pkg::WINDOW_MAX);
        end else begin
            w_k = swm_pkg::t_cnt'(r_window_size);
        end
    end

    swm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_smp.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    assign i_smp.ready = w_in_ready;

    swm_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_sample     (i_smp.sample_value),
        .i_array_end  (i_smp.array_end),
        .i_k          (w_k),
        .i_out_ready  (o_res.ready),
        .o_out_valid  (o_res.valid),
        .o_window_max (o_res.window_max),
        .o_last       (o_res.last_of_array)
    );

`ifndef SYNTH
    // one sample at a time: no accept in the cycle after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_smp.valid && i_smp.ready) |=> !i_smp.ready)
        else $error("sample accepted while previous one in flight");

    // pops only from a non-empty deque
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.drop_head || w_cmd.drop_tail) |-> !w_sts.occ_zero)
        else $error("pop from empty deque");

    // never overwrite a result that has not been taken
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> w_sts.out_free)
        else $error("output register overwritten");

    // a result beat only appears after an emit step
    a_rise_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(w_cmd.load_out))
        else $error("result beat without emit");
`endif

endmodule

// ===== hw/rtl/swm_ctrl.sv =====
// sequencing state machine: front pops, back pops, push, head read, emit
module swm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  swm_pkg::t_sts i_sts,
    output swm_pkg::t_cmd o_cmd
);

    swm_pkg::t_state r_state;
    swm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            swm_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = swm_pkg::ST_FRONT_RD;
                end
            end
            swm_pkg::ST_FRONT_RD:  n_state = swm_pkg::ST_FRONT_CHK;
            swm_pkg::ST_FRONT_CHK: begin
                if (!i_sts.occ_zero && i_sts.front_stale) begin
                    n_state = swm_pkg::ST_FRONT_RD;
                end else begin
                    n_state = swm_pkg::ST_BACK_RD;
                end
            end
            swm_pkg::ST_BACK_RD:   n_state = swm_pkg::ST_BACK_CHK;
            swm_pkg::ST_BACK_CHK: begin
                if (!i_sts.occ_zero && i_sts.back_drop) begin
                    n_state = swm_pkg::ST_BACK_RD;
                end else begin
                    n_state = swm_pkg::ST_PUSH;
                end
            end
            swm_pkg::ST_PUSH:      n_state = swm_pkg::ST_HEAD_RD;
            swm_pkg::ST_HEAD_RD:   n_state = swm_pkg::ST_EMIT;
            swm_pkg::ST_EMIT: begin
                if (!i_sts.emit_req || i_sts.out_free) begin
                    n_state = swm_pkg::ST_IDLE;
                end
            end
            default: n_state = swm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            swm_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            swm_pkg::ST_FRONT_RD: begin
                o_cmd.rd_en = 1'b1;
            end
            swm_pkg::ST_FRONT_CHK: begin
                o_cmd.drop_head = !i_sts.occ_zero && i_sts.front_stale;
            end
            swm_pkg::ST_BACK_RD: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_back = 1'b1;
            end
            swm_pkg::ST_BACK_CHK: begin
                o_cmd.drop_tail = !i_sts.occ_zero && i_sts.back_drop;
            end
            swm_pkg::ST_PUSH: begin
                o_cmd.push = 1'b1;
            end
            swm_pkg::ST_HEAD_RD: begin
                o_cmd.rd_en = 1'b1;
            end
            swm_pkg::ST_EMIT: begin
                o_cmd.load_out = i_sts.emit_req && i_sts.out_free;
                o_cmd.clear    = i_sts.emit_req && i_sts.out_free && i_sts.is_last;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/swm_dp.sv =====
// deque memory, pointers, counters, compares and output register
module swm_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  swm_pkg::t_cmd    i_cmd,
    output swm_pkg::t_sts    o_sts,
    input  swm_pkg::t_sample i_sample,
    input  logic             i_array_end,
    input  swm_pkg::t_cnt    i_k,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output swm_pkg::t_sample o_window_max,
    output logic             o_last
);

    swm_pkg::t_entry  mem [swm_pkg::WINDOW_MAX];
    swm_pkg::t_entry  r_rd;
    swm_pkg::t_slot   r_head;
    swm_pkg::t_slot   r_tail;
    swm_pkg::t_cnt    r_occ;
    swm_pkg::t_pos    r_pos;
    swm_pkg::t_cnt    r_fill;
    swm_pkg::t_sample r_v;
    logic             r_last;
    logic             r_out_valid;
    swm_pkg::t_sample r_out_max;
    logic             r_out_last;

    swm_pkg::t_slot   w_rd_addr;
    swm_pkg::t_pos    w_age;
    swm_pkg::t_pos    n_pos;
    logic             w_full;

    assign w_rd_addr = i_cmd.rd_back ? swm_pkg::slot_prev(r_tail) : r_head;
    assign w_full    = (int'(r_occ) == swm_pkg::WINDOW_MAX);

    // age of the head candidate, positions wrap at twice the window limit
    always_comb begin
        if (r_pos >= r_rd.pos) begin
            w_age = swm_pkg::t_pos'(r_pos - r_rd.pos);
        end else begin
            w_age = swm_pkg::t_pos'(swm_pkg::POS_MOD + int'(r_pos) - int'(r_rd.pos));
        end
    end

    assign n_pos = (int'(r_pos) == swm_pkg::POS_MOD - 1) ? swm_pkg::t_pos'(0)
                                                         : swm_pkg::t_pos'(r_pos + 1'b1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !w_full) begin
            mem[r_tail] <= '{value: r_v, pos: r_pos};
        end
        if (i_cmd.rd_en) begin
            r_rd <= mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_v    <= i_sample;
            r_last <= i_array_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_head <= '0;
            r_tail <= '0;
            r_occ  <= '0;
            r_pos  <= '0;
            r_fill <= '0;
        end else begin
            if (i_cmd.drop_head) begin
                r_head <= swm_pkg::slot_next(r_head);
                r_occ  <= swm_pkg::t_cnt'(r_occ - 1'b1);
            end
            if (i_cmd.drop_tail) begin
                r_tail <= swm_pkg::slot_prev(r_tail);
                r_occ  <= swm_pkg::t_cnt'(r_occ - 1'b1);
            end
            if (i_cmd.push) begin
                if (!w_full) begin
                    r_tail <= swm_pkg::slot_next(r_tail);
                    r_occ  <= swm_pkg::t_cnt'(r_occ + 1'b1);
                end
                r_pos <= n_pos;
                if (int'(r_fill) < swm_pkg::WINDOW_MAX) begin
                    r_fill <= swm_pkg::t_cnt'(r_fill + 1'b1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_max  <= r_rd.value;
            r_out_last <= r_last;
        end
    end

    assign o_sts.occ_zero    = (r_occ == '0);
    assign o_sts.front_stale = (int'(w_age) >= int'(i_k));
    assign o_sts.back_drop   = (r_v >= r_rd.value);
    assign o_sts.emit_req    = r_last || (r_fill >= i_k);
    assign o_sts.is_last     = r_last;
    assign o_sts.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_window_max = r_out_max;
    assign o_last       = r_out_last;

endmodule
